>>> rtl/kwat_pkg.sv
// Shared types and codes for the keyed weight accumulator table.
// Used by the entry store, the arithmetic unit and the top level; depends on nothing.
package kwat_pkg;

   localparam int KEY_W  = 32;
   localparam int VAR_W  = 8;
   localparam int WT_W   = 32;
   localparam int HELD_W = 6;
   localparam int PROD_W = 2 * WT_W;

   // Action codes carried on the request tuser.
   localparam logic [1:0] ACT_ADD   = 2'd0;
   localparam logic [1:0] ACT_SCALE = 2'd1;
   localparam logic [1:0] ACT_DRAIN = 2'd2;
   localparam logic [1:0] ACT_CLEAR = 2'd3;

   // Status codes carried on the response tuser.
   localparam logic [2:0] ST_APPEND = 3'd0;
   localparam logic [2:0] ST_MERGE  = 3'd1;
   localparam logic [2:0] ST_FULL   = 3'd2;
   localparam logic [2:0] ST_DONE   = 3'd3;
   localparam logic [2:0] ST_EMPTY  = 3'd4;
   localparam logic [2:0] ST_ENTRY  = 3'd5;

   localparam logic signed [WT_W-1:0] WT_MAX = {1'b0, {(WT_W-1){1'b1}}};
   localparam logic signed [WT_W-1:0] WT_MIN = {1'b1, {(WT_W-1){1'b0}}};

   typedef struct packed {
      logic [KEY_W-1:0]        key;
      logic [VAR_W-1:0]        vidx;
      logic signed [WT_W-1:0]  weight;
   } entry_type;

   typedef enum logic {
      ALU_ADD   = 1'b0,
      ALU_SCALE = 1'b1
   } alu_op_type;

   typedef struct packed {
      logic       mul_en;
      alu_op_type op;
   } alu_ctrl_type;

endpackage

>>> rtl/kwat_store.sv
// Entry memory of the accumulator table: one write port, one registered read port.
// Depends on kwat_pkg for the entry layout.
module kwat_store #(
   parameter int DEPTH = 32,
   parameter int AW    = 5
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [AW-1:0]       wr_addr,
   input  kwat_pkg::entry_type wr_data,
   input  logic                rd_en,
   input  logic [AW-1:0]       rd_addr,
   output kwat_pkg::entry_type rd_data
);
   import kwat_pkg::*;

   entry_type mem [DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/kwat_alu.sv
// Shared arithmetic unit: saturating add, registered multiply, and Q16.16 rescale.
// Depends on kwat_pkg for widths and the control struct.
module kwat_alu (
   input  logic                          clock,
   input  kwat_pkg::alu_ctrl_type        ctrl,
   input  logic signed [kwat_pkg::WT_W-1:0] a,
   input  logic signed [kwat_pkg::WT_W-1:0] b,
   output logic signed [kwat_pkg::WT_W-1:0] res
);
   import kwat_pkg::*;

   logic signed [PROD_W-1:0] prod_ff;
   logic signed [WT_W:0]     sum;
   logic signed [WT_W-1:0]   sum_sat;
   logic signed [PROD_W-1:0] biased;
   logic signed [PROD_W-17:0] shifted;
   logic signed [WT_W-1:0]   scale_sat;

   always_ff @(posedge clock) begin
      if (ctrl.mul_en) begin
         prod_ff <= a * b;
      end
   end

   always_comb begin
      sum = {a[WT_W-1], a} + {b[WT_W-1], b};
      if (sum[WT_W] != sum[WT_W-1]) begin
         sum_sat = sum[WT_W] ? WT_MIN : WT_MAX;
      end else begin
         sum_sat = sum[WT_W-1:0];
      end
   end

   // Division by 2^16 rounding toward zero: bias negative products before the shift.
   always_comb begin
      biased  = prod_ff + (prod_ff[PROD_W-1] ? PROD_W'(65535) : PROD_W'(0));
      shifted = biased[PROD_W-1:16];
      if (&shifted[PROD_W-17:WT_W-1] || ~|shifted[PROD_W-17:WT_W-1]) begin
         scale_sat = shifted[WT_W-1:0];
      end else begin
         scale_sat = shifted[PROD_W-17] ? WT_MIN : WT_MAX;
      end
   end

   always_comb begin
      case (ctrl.op)
         ALU_ADD:   res = sum_sat;
         ALU_SCALE: res = scale_sat;
         default:   res = sum_sat;
      endcase
   end

endmodule

>>> rtl/keyed_weight_accumulator_table_unit.sv
// Keyed weight accumulator table: sequencer over an entry memory and a shared ALU.
// Add scans the stored entries to merge or append, scale rescales each stored entry,
// drain issues a word per entry, and clear or an empty drain issues one word.
// One action is in work at a time; entries are read one by one via the single read port.
// Reset (synchronous, active high) empties the table and the output register;
// the entry memory itself is not cleared, as entries above the fill count are never read.
module keyed_weight_accumulator_table_unit #(
   parameter int CAPACITY = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,   // cell_key[31:0], var_index[39:32], value[71:40]
   input  logic [1:0]  req_tuser,   // action[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata,   // entry_key[31:0], entry_var[39:32],
                                    // entry_weight[71:40], entries_held[77:72], zero
   output logic [2:0]  rsp_tuser,   // status[2:0]
   output logic        rsp_tlast    // last word caused by the request word
);
   import kwat_pkg::*;

   localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_READ   = 5'b00010,
      S_CHECK  = 5'b00100,
      S_WRITE  = 5'b01000,
      S_FINISH = 5'b10000
   } state_type;

   state_type              state_ff, state_in;
   logic [1:0]             act_ff, act_in;
   logic [KEY_W-1:0]       key_ff, key_in;
   logic [VAR_W-1:0]       vidx_ff, vidx_in;
   logic signed [WT_W-1:0] val_ff, val_in;
   logic [IW-1:0]          idx_ff, idx_in;
   logic [CW-1:0]          fill_ff, fill_in;
   logic [2:0]             fin_ff, fin_in;

   // Output register, which lets the table take the next word while a result waits.
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [2:0]             rsp_status_ff, rsp_status_in;
   logic [KEY_W-1:0]       rsp_key_ff, rsp_key_in;
   logic [VAR_W-1:0]       rsp_var_ff, rsp_var_in;
   logic signed [WT_W-1:0] rsp_weight_ff, rsp_weight_in;
   logic [HELD_W-1:0]      rsp_held_ff, rsp_held_in;
   logic                   rsp_last_ff, rsp_last_in;

   logic                   mem_wr_en, mem_rd_en;
   logic [IW-1:0]          mem_wr_addr;
   entry_type              mem_wr_data, mem_rd_data;
   alu_ctrl_type           alu_ctrl;
   logic signed [WT_W-1:0] alu_res;

   logic                   accept, out_free, emit, hit, is_last;

   kwat_store #(
      .DEPTH (CAPACITY),
      .AW    (IW)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (idx_ff),
      .rd_data (mem_rd_data)
   );

   kwat_alu u_alu (
      .clock (clock),
      .ctrl  (alu_ctrl),
      .a     (mem_rd_data.weight),
      .b     (val_ff),
      .res   (alu_res)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign hit        = (mem_rd_data.key == key_ff) && (mem_rd_data.vidx == vidx_ff);
   assign is_last    = (CW'(idx_ff) + CW'(1)) == fill_ff;

   always_comb begin
      state_in      = state_ff;
      act_in        = act_ff;
      key_in        = key_ff;
      vidx_in       = vidx_ff;
      val_in        = val_ff;
      idx_in        = idx_ff;
      fill_in       = fill_ff;
      fin_in        = fin_ff;
      mem_wr_en     = 1'b0;
      mem_rd_en     = 1'b0;
      mem_wr_addr   = idx_ff;
      mem_wr_data   = mem_rd_data;
      alu_ctrl      = '{mul_en: 1'b0, op: ALU_ADD};
      emit          = 1'b0;
      rsp_status_in = ST_DONE;
      rsp_key_in    = '0;
      rsp_var_in    = '0;
      rsp_weight_in = '0;
      rsp_last_in   = 1'b1;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               act_in  = req_tuser;
               key_in  = req_tdata[31:0];
               vidx_in = req_tdata[39:32];
               val_in  = req_tdata[71:40];
               idx_in  = '0;
               unique case (req_tuser)
                  ACT_ADD: begin
                     fin_in   = ST_APPEND;
                     state_in = (fill_ff == '0) ? S_FINISH : S_READ;
                  end
                  ACT_SCALE: begin
                     fin_in   = ST_DONE;
                     state_in = (fill_ff == '0) ? S_FINISH : S_READ;
                  end
                  ACT_DRAIN: begin
                     fin_in   = ST_EMPTY;
                     state_in = (fill_ff == '0) ? S_FINISH : S_READ;
                  end
                  ACT_CLEAR: begin
                     fin_in   = ST_DONE;
                     state_in = S_FINISH;
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_READ: begin
            mem_rd_en = 1'b1;
            state_in  = S_CHECK;
         end
         S_CHECK: begin
            unique case (act_ff)
               ACT_ADD: begin
                  if (hit) begin
                     // Merge: saturating add and write back in the same cycle.
                     if (out_free) begin
                        alu_ctrl           = '{mul_en: 1'b0, op: ALU_ADD};
                        mem_wr_en          = 1'b1;
                        mem_wr_data.weight = alu_res;
                        emit               = 1'b1;
                        rsp_status_in      = ST_MERGE;
                        rsp_weight_in      = alu_res;
                        state_in           = S_IDLE;
                     end
                  end else if (is_last) begin
                     fin_in   = (fill_ff < CW'(CAPACITY)) ? ST_APPEND : ST_FULL;
                     state_in = S_FINISH;
                  end else begin
                     idx_in   = idx_ff + IW'(1);
                     state_in = S_READ;
                  end
               end
               ACT_SCALE: begin
                  alu_ctrl = '{mul_en: 1'b1, op: ALU_SCALE};
                  state_in = S_WRITE;
               end
               ACT_DRAIN: begin
                  if (out_free) begin
                     emit          = 1'b1;
                     rsp_status_in = ST_ENTRY;
                     rsp_key_in    = mem_rd_data.key;
                     rsp_var_in    = mem_rd_data.vidx;
                     rsp_weight_in = mem_rd_data.weight;
                     rsp_last_in   = is_last;
                     if (is_last) begin
                        state_in = S_IDLE;
                     end else begin
                        idx_in   = idx_ff + IW'(1);
                        state_in = S_READ;
                     end
                  end
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end
         S_WRITE: begin
            // The product of this entry sits in the ALU; rescale and store it.
            alu_ctrl           = '{mul_en: 1'b0, op: ALU_SCALE};
            mem_wr_en          = 1'b1;
            mem_wr_data.weight = alu_res;
            if (is_last) begin
               fin_in   = ST_DONE;
               state_in = S_FINISH;
            end else begin
               idx_in   = idx_ff + IW'(1);
               state_in = S_READ;
            end
         end
         S_FINISH: begin
            if (out_free) begin
               emit          = 1'b1;
               rsp_status_in = fin_ff;
               if (fin_ff == ST_APPEND) begin
                  mem_wr_en   = 1'b1;
                  mem_wr_addr = IW'(fill_ff);
                  mem_wr_data = '{key: key_ff, vidx: vidx_ff, weight: val_ff};
                  fill_in     = fill_ff + CW'(1);
                  rsp_weight_in = val_ff;
               end
               if (act_ff == ACT_CLEAR) begin
                  fill_in = '0;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // The count reported is the one left behind by this step.
      rsp_held_in = HELD_W'(fill_in);

      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff  <= act_in;
      key_ff  <= key_in;
      vidx_ff <= vidx_in;
      val_ff  <= val_in;
      idx_ff  <= idx_in;
      fin_ff  <= fin_in;
      if (emit) begin
         rsp_status_ff <= rsp_status_in;
         rsp_key_ff    <= rsp_key_in;
         rsp_var_ff    <= rsp_var_in;
         rsp_weight_ff <= rsp_weight_in;
         rsp_held_ff   <= rsp_held_in;
         rsp_last_ff   <= rsp_last_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {2'b00, rsp_held_ff, rsp_weight_ff, rsp_var_ff, rsp_key_ff};

   // The fill count never passes the table size.
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CW'(CAPACITY))
      else $error("fill count above capacity");

   // A memory write lands on a stored entry or on the next free slot.
   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      mem_wr_en |-> (CW'(mem_wr_addr) <= fill_ff))
      else $error("entry write beyond fill count");

   // The fill count moves only when a final word is issued.
   a_fill_moves_at_finish: assert property (@(posedge clock) disable iff (reset)
      !$stable(fill_ff) |-> $past(state_ff == S_FINISH && emit))
      else $error("fill count changed outside the finishing step");

endmodule
